// ----- rtl/core/rtuft_pkg.sv -----
`timescale 1ns / 1ps

package rtuft_pkg;

  // Field and register widths
  localparam int MODE_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int FRAME_LEN_W = 9;
  localparam int STATE_W     = 3;
  localparam int T_W         = 20;
  localparam int CHAR_W      = 16;
  localparam int TIMER_W     = 25;
  localparam int CRC_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 16;

  localparam int MAX_FRAME_DEF = 256;

  // Line states
  localparam logic [STATE_W-1:0] ST_INITIAL   = 3'd0;
  localparam logic [STATE_W-1:0] ST_IDLE      = 3'd1;
  localparam logic [STATE_W-1:0] ST_EMISSION  = 3'd2;
  localparam logic [STATE_W-1:0] ST_RECEPTION = 3'd3;
  localparam logic [STATE_W-1:0] ST_CTRLWAIT  = 3'd4;

  // Event codes
  localparam logic [MODE_W-1:0] EV_START  = 2'd0;
  localparam logic [MODE_W-1:0] EV_TICK   = 2'd1;
  localparam logic [MODE_W-1:0] EV_BYTE   = 2'd2;
  localparam logic [MODE_W-1:0] EV_DEMAND = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_T15  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T35  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR = 2'd2;

  localparam logic [T_W-1:0]    T15_RST  = 20'd750;
  localparam logic [T_W-1:0]    T35_RST  = 20'd1750;
  localparam logic [CHAR_W-1:0] CHAR_RST = 16'd500;
  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;

  // Result beat layout
  typedef struct packed {
    logic                   illegal_event;
    logic                   emit_enable;
    logic [FRAME_LEN_W-1:0] frame_len;
    logic                   frame_ok;
    logic [STATE_W-1:0]     line_state;
  } res_t;

  // Modbus CRC-16, one byte, reflected
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/rtu_frame_timing_fsm.sv -----
`timescale 1ns / 1ps
// Each event beat passes through an input register and then a result register.
// Throughput: one event per cycle while out_tready does not stall; the state update
// sits between the two registers, so back-to-back events each see the prior one's state.
// Reset (rst_n low, synchronous): initial state, timer stopped, frame cleared,
// timing registers back to 750 / 1750 / 500 ticks.

module rtu_frame_timing_fsm import rtuft_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // event input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] rx_byte, [16:8] tx_len, rest zero
  input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
  // result output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] line_state, [3] frame_ok,
                                            // [12:4] frame_len, [13] emit_enable,
                                            // [14] illegal_event, rest zero
  output logic                  out_tlast,  // frame_done
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [T_W-1:0]        cfg_data
);

  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int PROD_W = CNT_W + CHAR_W;
  localparam logic [FRAME_LEN_W-1:0] MAX_LEN = FRAME_LEN_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0]       MAX_CNT = CNT_W'(MAX_FRAME);

  // ---------------------------------------------------------------------------
  // Timing registers
  // ---------------------------------------------------------------------------
  logic [T_W-1:0]    t15_r, t35_r;
  logic [CHAR_W-1:0] char_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t15_r  <= T15_RST;
      t35_r  <= T35_RST;
      char_r <= CHAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_T15:  t15_r  <= cfg_data;
        CFG_T35:  t35_r  <= cfg_data;
        CFG_CHAR: char_r <= cfg_data[CHAR_W-1:0];
        default:  ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage. The emission length product is formed here so the state stage
  // only needs the add. The user must keep config stable while events are in flight;
  // the block itself does not enforce it. Using char_r at capture time relies on that.
  // ---------------------------------------------------------------------------
  logic                in_v_r;
  logic                out_v_r;
  logic [MODE_W-1:0]   mode_r;
  logic [BYTE_W-1:0]   rxb_r;
  logic [TIMER_W-1:0]  prod_r;
  logic                adv, proc;

  logic [FRAME_LEN_W-1:0] tx_len_in;
  logic [CNT_W-1:0]       len_sat;
  logic [PROD_W-1:0]      prod;

  assign adv       = !out_v_r || out_tready;
  assign proc      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  assign tx_len_in = in_tdata[BYTE_W +: FRAME_LEN_W];
  assign len_sat   = (tx_len_in > MAX_LEN) ? MAX_CNT : tx_len_in[CNT_W-1:0];
  assign prod      = {{CHAR_W{1'b0}}, len_sat} * {{CNT_W{1'b0}}, char_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= in_tuser;
      rxb_r  <= in_tdata[BYTE_W-1:0];
      prod_r <= TIMER_W'(prod);
    end
  end

  // ---------------------------------------------------------------------------
  // Line state and frame accumulators
  // ---------------------------------------------------------------------------
  logic [STATE_W-1:0] state_r,  state_nxt;
  logic [TIMER_W-1:0] cnt_dn_r, cnt_dn_nxt;
  logic               run_r,    run_nxt;
  logic [CNT_W-1:0]   bcnt_r,   bcnt_nxt;
  logic [CRC_W-1:0]   crc_r,    crc_nxt;
  logic [BYTE_W-1:0]  tail0_r,  tail0_nxt;
  logic [BYTE_W-1:0]  tail1_r,  tail1_nxt;
  logic               good_r,   good_nxt;
  res_t               res;
  logic               done;

  // control wait: T3.5 less 1.5 characters, floored at zero
  logic [CHAR_W+1:0]  half_char;
  logic [TIMER_W-1:0] cw_ticks;
  logic [TIMER_W-1:0] emit_ticks;

  assign half_char  = {2'b00, char_r} + {3'b000, char_r[CHAR_W-1:1]};
  assign cw_ticks   = (TIMER_W'(t35_r) > TIMER_W'(half_char)) ?
                      TIMER_W'(t35_r) - TIMER_W'(half_char) : '0;
  assign emit_ticks = TIMER_W'(t35_r) + prod_r;

  always_comb begin
    logic             take;
    logic [CNT_W-1:0] c_cnt;
    logic [CRC_W-1:0] c_crc;
    logic [BYTE_W-1:0] c_t0, c_t1;

    state_nxt  = state_r;
    cnt_dn_nxt = cnt_dn_r;
    run_nxt    = run_r;
    bcnt_nxt   = bcnt_r;
    crc_nxt    = crc_r;
    tail0_nxt  = tail0_r;
    tail1_nxt  = tail1_r;
    good_nxt   = good_r;
    done       = 1'b0;
    res        = '0;
    take       = 1'b0;

    // frame base for a taken byte: a fresh frame when leaving idle
    if (state_r == ST_IDLE) begin
      c_cnt = '0;
      c_crc = CRC_INIT;
      c_t0  = '0;
      c_t1  = '0;
    end else begin
      c_cnt = bcnt_r;
      c_crc = crc_r;
      c_t0  = tail0_r;
      c_t1  = tail1_r;
    end

    case (mode_r)
      EV_TICK: begin
        if (run_r) begin
          if (cnt_dn_r <= TIMER_W'(1)) begin
            cnt_dn_nxt = '0;
            run_nxt    = 1'b0;
            case (state_r)
              ST_RECEPTION: begin
                cnt_dn_nxt = cw_ticks;
                run_nxt    = 1'b1;
                good_nxt   = (bcnt_r >= CNT_W'(2)) &&
                             (tail0_r == crc_r[CRC_W-1:BYTE_W]) &&
                             (tail1_r == crc_r[BYTE_W-1:0]);
                state_nxt  = ST_CTRLWAIT;
              end
              ST_CTRLWAIT: begin
                done          = 1'b1;
                res.frame_ok  = good_r;
                res.frame_len = FRAME_LEN_W'(bcnt_r);
                bcnt_nxt      = '0;
                crc_nxt       = CRC_INIT;
                tail0_nxt     = '0;
                tail1_nxt     = '0;
                good_nxt      = 1'b0;
                state_nxt     = ST_IDLE;
              end
              default: state_nxt = ST_IDLE;
            endcase
          end else begin
            cnt_dn_nxt = cnt_dn_r - TIMER_W'(1);
          end
        end
      end
      EV_START: begin
        if (state_r == ST_INITIAL) begin
          cnt_dn_nxt = TIMER_W'(t35_r);
          run_nxt    = 1'b1;
        end else begin
          res.illegal_event = 1'b1;
        end
      end
      EV_BYTE: begin
        case (state_r)
          ST_INITIAL: begin
            cnt_dn_nxt = TIMER_W'(t35_r);
            run_nxt    = 1'b1;
          end
          ST_IDLE, ST_RECEPTION: begin
            take       = 1'b1;
            cnt_dn_nxt = TIMER_W'(t15_r);
            run_nxt    = 1'b1;
            state_nxt  = ST_RECEPTION;
          end
          ST_CTRLWAIT: good_nxt = 1'b0;   // late byte spoils the frame
          default:     res.illegal_event = 1'b1;
        endcase
      end
      default: begin  // emission demand
        if (state_r == ST_IDLE) begin
          cnt_dn_nxt = emit_ticks;
          run_nxt    = 1'b1;
          state_nxt  = ST_EMISSION;
        end else begin
          res.illegal_event = 1'b1;
        end
      end
    endcase

    if (take) begin
      bcnt_nxt  = c_cnt;
      crc_nxt   = c_crc;
      tail0_nxt = c_t0;
      tail1_nxt = c_t1;
      if (state_r == ST_IDLE) begin
        good_nxt = 1'b0;
      end
      // bytes past the maximum frame length are dropped
      if (c_cnt < MAX_CNT) begin
        if (c_cnt >= CNT_W'(2)) begin
          crc_nxt = crc_feed(c_crc, c_t0);
        end
        tail0_nxt = c_t1;
        tail1_nxt = rxb_r;
        bcnt_nxt  = c_cnt + CNT_W'(1);
      end
    end

    res.line_state  = state_nxt;
    res.emit_enable = (state_nxt == ST_EMISSION);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INITIAL;
      cnt_dn_r <= '0;
      run_r    <= 1'b0;
      bcnt_r   <= '0;
      crc_r    <= CRC_INIT;
      tail0_r  <= '0;
      tail1_r  <= '0;
      good_r   <= 1'b0;
    end else if (proc) begin
      state_r  <= state_nxt;
      cnt_dn_r <= cnt_dn_nxt;
      run_r    <= run_nxt;
      bcnt_r   <= bcnt_nxt;
      crc_r    <= crc_nxt;
      tail0_r  <= tail0_nxt;
      tail1_r  <= tail1_nxt;
      good_r   <= good_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  res_t res_r;
  logic last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r  <= res;
      last_r <= done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(res_r);
  assign out_tlast  = last_r;

endmodule

// ----- rtl/core/rtuft_checker.sv -----
`timescale 1ns / 1ps

module rtuft_checker import rtuft_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  res_t r;
  assign r = res_t'(out_tdata[$bits(res_t)-1:0]);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (r.emit_enable == (r.line_state == ST_EMISSION)))
    else $error("emit_enable disagrees with line state");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (r.line_state == ST_IDLE) && !r.illegal_event)
    else $error("frame end not into idle");

  a_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !r.frame_ok && (r.frame_len == '0))
    else $error("frame report without frame end");

endmodule

bind rtu_frame_timing_fsm rtuft_checker u_rtuft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/sv/tb_rtu_frame_timing_fsm.sv -----
`timescale 1ns / 1ps

// Line-timing FSM bench: every accepted event beat is run through a local model of the
// line state machine, and the result beat it causes is queued; the receiver compares each
// result beat with the oldest queued one, field by field.
module tb_rtu_frame_timing_fsm;
  import rtuft_pkg::*;

  localparam int FRAME_CAP = MAX_FRAME_DEF;

  // One result beat, unpacked into its fields
  typedef struct packed {
    logic [STATE_W-1:0]     line_state;
    logic                   done;
    logic                   ok;
    logic [FRAME_LEN_W-1:0] flen;
    logic                   emit;
    logic                   illegal;
  } line_result_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // Block ports; every input starts at a known value
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [MODE_W-1:0]     in_tuser  = EV_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_T15;
  logic [T_W-1:0]        cfg_data  = '0;

  rtu_frame_timing_fsm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Line model: timing registers, then the FSM state as it stands after every
  // event beat accepted so far (the stimulus steers itself off this too).
  // ---------------------------------------------------------------------------
  logic [T_W-1:0]     t15 = T15_RST;
  logic [T_W-1:0]     t35 = T35_RST;
  logic [CHAR_W-1:0]  chr = CHAR_RST;

  logic [STATE_W-1:0] line_st = ST_INITIAL;
  logic [TIMER_W-1:0] cnt     = '0;
  logic               tmr_on  = 1'b0;
  int                 nbytes  = 0;
  logic [CRC_W-1:0]   crc_acc = 16'hFFFF;
  logic [7:0]         tail0   = '0;
  logic [7:0]         tail1   = '0;
  logic               good    = 1'b0;

  line_result_t pending_results[$];
  int           beats_sent  = 0;
  int           fails       = 0;
  int           results_seen = 0;

  // Handshake pacing
  bit tx_calm    = 1'b0;   // sender: no gaps
  bit rx_calm    = 1'b0;   // receiver: no random stalls
  int stall_left = 0;      // long receiver hold-off, counted down by the receiver
  int rx_wait    = 0;

  // Modbus CRC-16, bit-serial form of the reflected 0xA001 polynomial
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ 16'hA001;
    end
    return c;
  endfunction

  function automatic void frame_reset();
    nbytes  = 0;
    crc_acc = 16'hFFFF;
    tail0   = '0;
    tail1   = '0;
    good    = 1'b0;
  endfunction

  // CRC runs two bytes behind so the last two can be compared with it
  function automatic void frame_take(input logic [7:0] b);
    if (nbytes < FRAME_CAP) begin
      if (nbytes >= 2) crc_acc = crc16_byte(crc_acc, tail0);
      tail0  = tail1;
      tail1  = b;
      nbytes = nbytes + 1;
    end
  endfunction

  function automatic void timer_load(input int unsigned n);
    cnt    = n[TIMER_W-1:0];
    tmr_on = 1'b1;
  endfunction

  function automatic line_result_t predict_line_event(input logic [MODE_W-1:0] mode,
                                                      input logic [7:0] rxb,
                                                      input logic [8:0] txl);
    line_result_t r;
    int unsigned  half;
    int unsigned  len;
    r = '0;
    case (mode)
      EV_TICK: begin
        // a stopped timer ignores ticks
        if (tmr_on) begin
          if (cnt <= 1) begin
            cnt    = '0;
            tmr_on = 1'b0;
            case (line_st)
              ST_RECEPTION: begin
                // T1.5 gone: wait out the rest of T3.5, floored at zero
                half = (3 * int'(chr)) / 2;
                timer_load((t35 > half) ? t35 - half : 0);
                good = (nbytes >= 2) && (tail0 == crc_acc[15:8]) &&
                       (tail1 == crc_acc[7:0]);
                line_st = ST_CTRLWAIT;
              end
              ST_CTRLWAIT: begin
                r.done  = 1'b1;
                r.ok    = good;
                r.flen  = nbytes[8:0];
                frame_reset();
                line_st = ST_IDLE;
              end
              default: line_st = ST_IDLE;
            endcase
          end else begin
            cnt = cnt - 1'b1;
          end
        end
      end
      EV_START: begin
        if (line_st == ST_INITIAL) timer_load(32'(t35));
        else r.illegal = 1'b1;
      end
      EV_BYTE: begin
        case (line_st)
          ST_INITIAL: timer_load(32'(t35));
          ST_IDLE: begin
            frame_reset();
            frame_take(rxb);
            timer_load(32'(t15));
            line_st = ST_RECEPTION;
          end
          ST_RECEPTION: begin
            frame_take(rxb);
            timer_load(32'(t15));
          end
          ST_CTRLWAIT: good = 1'b0;   // late byte spoils the frame
          default: r.illegal = 1'b1;
        endcase
      end
      default: begin
        if (line_st == ST_IDLE) begin
          len = (txl > FRAME_CAP) ? FRAME_CAP : txl;
          timer_load(t35 + len * chr);
          line_st = ST_EMISSION;
        end else begin
          r.illegal = 1'b1;
        end
      end
    endcase
    r.line_state = line_st;
    r.emit       = (line_st == ST_EMISSION);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: checks each result beat, then decides its own stall
  // ---------------------------------------------------------------------------
  line_result_t got, want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.line_state = out_tdata[2:0];
      got.ok         = out_tdata[3];
      got.flen       = out_tdata[12:4];
      got.emit       = out_tdata[13];
      got.illegal    = out_tdata[14];
      got.done       = out_tlast;
      results_seen   = results_seen + 1;
      if (pending_results.size() == 0) begin
        fails = fails + 1;
        if (fails <= 10) $display("result beat %0d arrived with nothing queued", results_seen);
      end else begin
        want = pending_results.pop_front();
        if (got.line_state !== want.line_state || got.done !== want.done ||
            got.ok !== want.ok || got.flen !== want.flen ||
            got.emit !== want.emit || got.illegal !== want.illegal) begin
          fails = fails + 1;
          if (fails <= 10) begin
            $display("result beat %0d wrong: exp st=%0d done=%0b ok=%0b len=%0d emit=%0b ill=%0b",
                     results_seen, want.line_state, want.done, want.ok, want.flen,
                     want.emit, want.illegal);
            $display("                     got st=%0d done=%0b ok=%0b len=%0d emit=%0b ill=%0b",
                     got.line_state, got.done, got.ok, got.flen, got.emit, got.illegal);
          end
        end
      end
      rx_wait = rx_calm ? 0 : $urandom_range(0, 13);
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Every task starts and ends on a rising edge.
  // ---------------------------------------------------------------------------

  // One event beat; tvalid is left high so a gapless next beat follows directly
  task automatic send_event(input logic [MODE_W-1:0] mode, input logic [7:0] rxb,
                            input logic [8:0] txl);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'd0, txl, rxb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_line_event(mode, rxb, txl));
    beats_sent = beats_sent + 1;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_event(EV_TICK, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
  endtask

  // Stop offering and wait for every queued result, plus some slack
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [T_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_T15:  t15 = val;
      CFG_T35:  t35 = val;
      CFG_CHAR: chr = val[CHAR_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input int unsigned a, input int unsigned b, input int unsigned c);
    settle();
    write_reg(CFG_T15, T_W'(a));
    write_reg(CFG_T35, T_W'(b));
    write_reg(CFG_CHAR, T_W'(c));
  endtask

  // Demand length kept so that emission stays short at the current char time
  function automatic logic [8:0] pick_len();
    if (chr == 1 && $urandom_range(0, 3) == 0) return 9'($urandom_range(0, 511));
    if (chr <= 12) return 9'($urandom_range(0, 7));
    return 9'd0;
  endfunction

  // Tick the line back to idle, with the odd late byte or illegal event on the way
  task automatic drive_to_idle();
    while (line_st != ST_IDLE) begin
      if (line_st == ST_INITIAL && !tmr_on)
        send_event(EV_START, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      else if (line_st == ST_CTRLWAIT && $urandom_range(0, 7) == 0)
        send_event(EV_BYTE, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      else if (line_st == ST_EMISSION && $urandom_range(0, 15) == 0)
        send_event($urandom_range(0, 1) ? EV_BYTE : EV_DEMAND, 8'($urandom_range(0, 255)),
                   9'($urandom_range(0, 511)));
      else
        send_ticks(1);
    end
  endtask

  // Receive one frame: random body, usually with a correct CRC (high byte first),
  // mostly legal character gaps and now and then one long enough to split the frame
  task automatic run_frame();
    logic [7:0]  body[$];
    logic [15:0] c;
    int          n;
    int          gap;
    drive_to_idle();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
    c = 16'hFFFF;
    repeat (n) begin
      body.push_back(8'($urandom_range(0, 255)));
      c = crc16_byte(c, body[body.size()-1]);
    end
    if ($urandom_range(0, 3) != 0) begin
      body.push_back(c[15:8]);
      body.push_back(c[7:0]);
      if ($urandom_range(0, 5) == 0) body[$urandom_range(0, body.size()-1)] ^= 8'h10;
    end
    if (body.size() == 0) body.push_back(8'($urandom_range(0, 255)));
    foreach (body[i]) begin
      send_event(EV_BYTE, body[i], 9'($urandom_range(0, 511)));
      if (i != body.size() - 1) begin
        gap = ($urandom_range(0, 11) == 0) ? t15 + $urandom_range(0, 2)
                                           : $urandom_range(0, t15 - 1);
        send_ticks(gap);
      end
    end
    drive_to_idle();
  endtask

  task automatic run_emission();
    drive_to_idle();
    if ($urandom_range(0, 4) == 0) send_event(EV_START, 8'($urandom_range(0, 255)), pick_len());
    send_event(EV_DEMAND, 8'($urandom_range(0, 255)), pick_len());
    drive_to_idle();
  endtask

  // Fully random events, with demand lengths tamed only where they would arm a timer
  task automatic run_noise();
    logic [MODE_W-1:0] m;
    logic [8:0]        l;
    repeat ($urandom_range(3, 10)) begin
      m = 2'($urandom_range(0, 3));
      l = (m == EV_DEMAND && line_st == ST_IDLE) ? pick_len() : 9'($urandom_range(0, 511));
      send_event(m, 8'($urandom_range(0, 255)), l);
    end
  endtask

  task automatic run_phase(input int unsigned a, input int unsigned b, input int unsigned c,
                           input int n);
    int first;
    int pick;
    set_timing(a, b, c);
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    first   = beats_sent;
    while (beats_sent - first < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) run_frame();
      else if (pick < 15) run_emission();
      else if (pick < 18) run_noise();
      else if (pick == 18) tx_calm = !tx_calm;
      else rx_calm = !rx_calm;
    end
    drive_to_idle();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset timing: stopped tick, illegal demand, start and a byte in initial
  task automatic test_reset_defaults();
    send_event(EV_TICK, 8'hFF, 9'h1FF);
    send_event(EV_DEMAND, 8'h00, 9'h000);
    send_event(EV_START, 8'h5A, 9'h0A5);
    send_event(EV_BYTE, 8'h00, 9'h100);
    send_ticks(1);
  endtask

  // Short timers; every event in every state it matters, and one good frame
  task automatic test_directed();
    logic [15:0] c;
    set_timing(2, 3, 1);
    send_event(EV_START, 8'h00, 9'h000);     // rearm at T3.5 = 3
    send_ticks(3);                           // -> idle
    send_event(EV_START, 8'h00, 9'h000);     // illegal outside initial
    send_ticks(1);                           // timer stopped
    send_event(EV_DEMAND, 8'hFF, 9'h000);    // zero-length emission
    send_event(EV_BYTE, 8'hFF, 9'h000);      // illegal while sending
    send_event(EV_DEMAND, 8'h00, 9'h100);    // illegal outside idle
    send_ticks(3);                           // -> idle
    c = crc16_byte(crc16_byte(16'hFFFF, 8'hFF), 8'h00);
    send_event(EV_BYTE, 8'hFF, 9'h1FF);
    send_event(EV_BYTE, 8'h00, 9'h000);
    send_event(EV_BYTE, c[15:8], 9'h000);
    send_event(EV_BYTE, c[7:0], 9'h000);
    send_ticks(2);                           // -> control wait
    send_ticks(2);                           // frame reported
  endtask

  // Full-size frame with a good CRC, then bytes past the cap that must be dropped
  task automatic test_overlong_frame();
    logic [7:0]  body[$];
    logic [15:0] c;
    set_timing(3, 2, 1);
    drive_to_idle();
    c = 16'hFFFF;
    repeat (FRAME_CAP - 2) begin
      body.push_back(8'($urandom_range(0, 255)));
      c = crc16_byte(c, body[body.size()-1]);
    end
    body.push_back(c[15:8]);
    body.push_back(c[7:0]);
    repeat (3) body.push_back(8'($urandom_range(0, 255)));
    foreach (body[i]) send_event(EV_BYTE, body[i], 9'($urandom_range(0, 511)));
    drive_to_idle();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int first;
    settle();
    tx_calm    = 1'b1;
    stall_left = 300;
    first      = beats_sent;
    while (beats_sent - first < 80) run_frame();
    settle();                                // sender waits for every result
    tx_calm = 1'b0;
  endtask

  task automatic test_random_phases();
    run_phase(1, 1, 1, 200);                 // minimum timings
    run_phase(4, 9, 1, 200);
    run_phase(3, 12, 2, 200);
    run_phase(6, 5, 9, 200);                 // control wait floored at zero
    run_phase(2, 20, 65535, 190);            // longest character time
    run_phase($urandom_range(1, 10), $urandom_range(1, 24), $urandom_range(1, 12), 200);
    run_phase($urandom_range(1, 10), $urandom_range(1, 24), $urandom_range(1, 12), 200);
  endtask

  // Maximum timings: longest emission the arithmetic allows, never run to expiry
  task automatic test_extreme_timing();
    drive_to_idle();
    set_timing(32'hFFFFF, 32'hFFFFF, 32'hFFFF);
    send_event(EV_DEMAND, 8'hA5, 9'h1FF);
    send_ticks(8);
    send_event(EV_BYTE, 8'hFF, 9'h000);
    send_event(EV_START, 8'h00, 9'h1FF);
    send_event(EV_DEMAND, 8'h00, 9'h100);
    send_ticks(4);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_overlong_frame();
    test_backpressure();
    test_random_phases();
    test_extreme_timing();
    settle();
    repeat (12) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
